### hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DqDepth    = 8;
  localparam int unsigned DqDataW    = 32;
  localparam int unsigned DqFillW    = 4;

  typedef enum logic [1:0] {
    OpPushFront = 2'd0,
    OpPushBack  = 2'd1,
    OpPopFront  = 2'd2,
    OpPopBack   = 2'd3
  } dq_op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } dq_status_e;

  // Response flags from the controller to the output stage.
  typedef struct packed {
    logic                 done;
    logic                 pop_ok;
    dq_status_e           status;
    logic [DqFillW-1:0]   fill;
  } dq_rsp_t;

endpackage

### hw/rtl/dq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dq_ctrl.sv
// Deque controller: head pointer, entry count, RAM address generation, response flags.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_ctrl import dq_pkg::*; #(
  parameter int unsigned DEPTH = DqDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_i,
  input  logic [1:0]               op_i,
  output logic                     we_o,
  output logic                     re_o,
  output logic [$clog2(DEPTH)-1:0] addr_o,
  output dq_rsp_t                  rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  dq_rsp_t       rsp_q, rsp_d;

  logic          full, empty;
  logic [AW-1:0] head_dec, head_inc, back_wr, back_rd;
  logic [SW-1:0] sum_wr, sum_rd;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  // Back positions: head + count (push) and head + count - 1 (pop), wrapped.
  assign sum_wr  = SW'(head_q) + SW'(count_q);
  assign sum_rd  = sum_wr - SW'(1);
  assign back_wr = (sum_wr >= SW'(DEPTH)) ? AW'(sum_wr - SW'(DEPTH)) : AW'(sum_wr);
  assign back_rd = (sum_rd >= SW'(DEPTH)) ? AW'(sum_rd - SW'(DEPTH)) : AW'(sum_rd);

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    we_o         = 1'b0;
    re_o         = 1'b0;
    addr_o       = head_q;
    rsp_d        = '0;
    rsp_d.status = StOk;
    if (req_i) begin
      rsp_d.done = 1'b1;
      case (dq_op_e'(op_i))
        OpPushFront: begin
          if (full) begin
            rsp_d.status = StFull;
          end else begin
            head_d  = head_dec;
            addr_o  = head_dec;
            we_o    = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        OpPushBack: begin
          if (full) begin
            rsp_d.status = StFull;
          end else begin
            addr_o  = back_wr;
            we_o    = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        OpPopFront: begin
          if (empty) begin
            rsp_d.status = StEmpty;
          end else begin
            addr_o       = head_q;
            re_o         = 1'b1;
            head_d       = head_inc;
            count_d      = count_q - CW'(1);
            rsp_d.pop_ok = 1'b1;
          end
        end
        OpPopBack: begin
          if (empty) begin
            rsp_d.status = StEmpty;
          end else begin
            addr_o       = back_rd;
            re_o         = 1'b1;
            count_d      = count_q - CW'(1);
            rsp_d.pop_ok = 1'b1;
          end
        end
        default: begin
          rsp_d.done = 1'b1;
        end
      endcase
      rsp_d.fill = DqFillW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rsp_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rsp_q   <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

### hw/rtl/double_ended_queue_top.sv
// Top level of the bounded double-ended queue of signed 32-bit words (dq_pkg, dq_ram, dq_ctrl).
// Every request gives its result in the cycle after acceptance (done_o strobe).
// One request per cycle while busy is low; the store is a single RAM with registered read.
// Reset: asynchronous, active low; clears head and count, busy high for one cycle after.
// Stored words are not cleared; only entries already pushed are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module double_ended_queue_top import dq_pkg::*; #(
  parameter int unsigned DEPTH = DqDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request side
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic signed [DqDataW-1:0] value_i,
  // result side
  output logic                      done_o,
  output logic signed [DqDataW-1:0] popped_o,
  output logic [1:0]                status_o,
  output logic [DqFillW-1:0]        fill_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic               busy_q;
  logic               req;
  logic               we, re;
  logic [AW-1:0]      addr;
  logic [DqDataW-1:0] rdata;
  dq_rsp_t            rsp;

  // Hold requests off for the first cycle out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;
  assign req  = start && !busy_q;

  // Controller works out the slot, updates pointers and issues at most one RAM access.
  dq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .op_i   (op_i),
    .we_o   (we),
    .re_o   (re),
    .addr_o (addr),
    .rsp_o  (rsp)
  );

  // Slot store. A push then a pop of the same slot fall in different cycles,
  // so the write has landed before the read: no forwarding needed.
  dq_ram #(
    .WIDTH (DqDataW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // Result: registered flags from the controller, word from the RAM read register, zeroed unless a pop succeeded.
  assign done_o   = rsp.done;
  assign status_o = rsp.status;
  assign fill_o   = rsp.fill;
  assign popped_o = rsp.pop_ok ? signed'(rdata) : '0;

endmodule

### hw/rtl/dq_checker.sv
// Port-level assertions for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue_top.
`timescale 1ns / 1ps

module dq_props import dq_pkg::*; #(
  parameter int unsigned DEPTH = DqDepth
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic signed [DqDataW-1:0] popped_o,
  input logic [1:0]                status_o,
  input logic [DqFillW-1:0]        fill_o
);

  // One result per request, in the cycle after it.
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o) else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o) else $error("result without request");

  // Failed requests carry no word.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> (popped_o == '0)) else $error("word on error");

  // Full push reports the full count, empty pop an empty count.
  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StFull) |-> (fill_o == DqFillW'(DEPTH)))
    else $error("full with wrong fill");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StEmpty) |-> (fill_o == '0)) else $error("empty with fill");

endmodule

bind double_ended_queue_top dq_props #(.DEPTH(DEPTH)) u_dq_props (.*);

### tb/dq_checker.sv
// Checker for the double-ended queue: keeps a shadow copy of the deque, predicts each
// result from the accepted requests and compares it with what the block reports.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_checker import dq_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                op_i,
  input  logic signed [DqDataW-1:0] value_i,
  input  logic                      done_i,
  input  logic signed [DqDataW-1:0] popped_i,
  input  logic [1:0]                status_i,
  input  logic [DqFillW-1:0]        fill_i,
  output int unsigned               err_count_o,
  output int unsigned               pending_o,
  output int unsigned               req_count_o,
  output int unsigned               full_count_o,
  output int unsigned               empty_count_o
);

  typedef struct packed {
    logic signed [DqDataW-1:0] popped;
    dq_status_e                status;
    logic [DqFillW-1:0]        fill;
  } deque_resp_t;

  logic signed [DqDataW-1:0] shadow_slots [DqDepth];
  int unsigned               shadow_head;
  int unsigned               shadow_count;
  deque_resp_t               due_responses [$];

  // Applies one request to the shadow deque and returns the response it should give.
  function automatic deque_resp_t apply_deque_request(dq_op_e req_op,
                                                      logic signed [DqDataW-1:0] word);
    deque_resp_t resp;
    int unsigned slot;
    resp.popped = '0;
    resp.status = StOk;
    case (req_op)
      OpPushFront, OpPushBack: begin
        if (shadow_count >= DqDepth) begin
          resp.status = StFull;
        end else begin
          if (req_op == OpPushFront) begin
            shadow_head = (shadow_head + DqDepth - 1) % DqDepth;
            slot = shadow_head;
          end else begin
            slot = (shadow_head + shadow_count) % DqDepth;
          end
          shadow_slots[slot] = word;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          resp.status = StEmpty;
        end else begin
          if (req_op == OpPopFront) begin
            slot = shadow_head;
            shadow_head = (shadow_head + 1) % DqDepth;
          end else begin
            slot = (shadow_head + shadow_count - 1) % DqDepth;
          end
          resp.popped = shadow_slots[slot];
          shadow_count--;
        end
      end
    endcase
    resp.fill = shadow_count[DqFillW-1:0];
    return resp;
  endfunction

  function automatic void check_field(string field, logic [DqDataW-1:0] want,
                                      logic [DqDataW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      err_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_resp_t want;
    if (!rst_ni) begin
      shadow_head   = 0;
      shadow_count  = 0;
      due_responses.delete();
      err_count_o   = 0;
      pending_o     = 0;
      req_count_o   = 0;
      full_count_o  = 0;
      empty_count_o = 0;
    end else begin
      // results first: a request accepted at this edge cannot answer at the same edge
      if (done_i) begin
        if (due_responses.size() == 0) begin
          $display("%0t ns: result with none due, expected nothing, got popped %h status %0d fill %0d",
                   $time, popped_i, status_i, fill_i);
          err_count_o++;
        end else begin
          want = due_responses.pop_front();
          check_field("popped", want.popped, popped_i);
          check_field("status", DqDataW'(want.status), DqDataW'(status_i));
          check_field("fill", DqDataW'(want.fill), DqDataW'(fill_i));
        end
      end
      if (start_i && !busy_i) begin
        want = apply_deque_request(dq_op_e'(op_i), value_i);
        due_responses.push_back(want);
        req_count_o++;
        if (want.status == StFull) full_count_o++;
        if (want.status == StEmpty) empty_count_o++;
      end
      pending_o = due_responses.size();
    end
  end

endmodule

### tb/tb_double_ended_queue_top.sv
// Testbench top for the double-ended queue: drives requests into the block and gives the
// verdict; prediction and comparison sit in dq_checker.
// Depends on dq_pkg, dq_checker and double_ended_queue_top.
`timescale 1ns / 1ps

module tb_double_ended_queue_top;
  import dq_pkg::*;

  // random requests spread over three idling phases
  localparam int unsigned RandomRequests = 1330;
  localparam int unsigned PhaseCount     = 3;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                op;
  logic signed [DqDataW-1:0] value;
  logic                      done;
  logic signed [DqDataW-1:0] popped;
  logic [1:0]                status;
  logic [DqFillW-1:0]        fill;

  int unsigned err_count;
  int unsigned pending;
  int unsigned req_count;
  int unsigned full_count;
  int unsigned empty_count;

  // 4 ns period
  always #2 clk = ~clk;

  double_ended_queue_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start   (start),
    .busy    (busy),
    .op_i    (op),
    .value_i (value),
    .done_o  (done),
    .popped_o(popped),
    .status_o(status),
    .fill_o  (fill)
  );

  dq_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .op_i         (op),
    .value_i      (value),
    .done_i       (done),
    .popped_i     (popped),
    .status_i     (status),
    .fill_i       (fill),
    .err_count_o  (err_count),
    .pending_o    (pending),
    .req_count_o  (req_count),
    .full_count_o (full_count),
    .empty_count_o(empty_count)
  );

  // Present a request from a falling edge and hold it until a rising edge sees busy low.
  // start is left high on return, so back-to-back requests never drop it.
  task automatic send_request(dq_op_e req_op, logic [DqDataW-1:0] word);
    start <= 1'b1;
    op    <= req_op;
    value <= word;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off until every predicted result has come back. At least one edge passes, so
  // start is never lowered and raised in the same step.
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Mostly random words, with the corners of the signed range mixed in.
  function automatic logic [DqDataW-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Filling bursts lean on pushes, draining bursts on pops, so the queue swings between
  // empty and full and both pointers wrap often.
  function automatic dq_op_e pick_op(int unsigned lean);
    int unsigned roll;
    logic        is_push;
    roll = $urandom_range(99);
    case (lean)
      0:       is_push = (roll < 75);
      1:       is_push = (roll < 25);
      default: is_push = (roll < 50);
    endcase
    if (is_push) return $urandom_range(1) ? OpPushBack : OpPushFront;
    return $urandom_range(1) ? OpPopBack : OpPopFront;
  endfunction

  initial begin
    logic [DqDataW-1:0] corner_words [8];
    int unsigned        idle_pct [PhaseCount];
    int unsigned        burst_left;
    int unsigned        lean;
    int unsigned        guard;

    corner_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                     32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'h1234_5678};
    // sender idles rarely, then mostly, then never
    idle_pct = '{9, 80, 0};

    rst_n = 1'b0;
    start = 1'b0;
    op    = OpPushFront;
    value = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Pops on an empty queue, with a random ignored word.
    send_request(OpPopFront, $urandom);
    send_request(OpPopBack, $urandom);
    // Fill to the brim from both ends with corner values; the first front push wraps
    // the head below zero.
    for (int i = 0; i < DqDepth; i++) begin
      send_request(i[0] ? OpPushBack : OpPushFront, corner_words[i]);
    end
    // pushes into a full queue are dropped
    send_request(OpPushFront, 32'hdead_beef);
    send_request(OpPushBack, 32'hcafe_f00d);
    // drain from alternate ends to check deque order
    for (int i = 0; i < DqDepth; i++) begin
      send_request(i[0] ? OpPopBack : OpPopFront, $urandom);
    end
    send_request(OpPopBack, $urandom);
    // sender waits for every outstanding result before the random part
    wait_until_drained();

    // Random part in three phases, draining between phases.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      burst_left = 0;
      lean       = 2;
      for (int n = 0; n < RandomRequests / PhaseCount; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(10, 40);
          lean       = $urandom_range(2);
        end
        burst_left--;
        // each cycle is idle with the phase's odds, so idle cycles make up that share
        while ($urandom_range(99) < idle_pct[phase]) pause_sender(1);
        send_request(pick_op(lean), pick_word());
      end
      wait_until_drained();
    end

    // End of stimulus: let the last results land, with a limit, then a few quiet cycles.
    start <= 1'b0;
    for (guard = 0; guard < 1000 && pending != 0; guard++) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Ran %0d requests through the deque, %0d pushes refused as full,",
             req_count, full_count);
    $display("%0d pops on empty; both ends used under three sender idling patterns.",
             empty_count);
    if (err_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
